FILE: rtl/plds_pkg.sv
`timescale 1ns / 1ps
package plds_pkg;

	localparam int MAX_LIGHTS = 16;
	localparam int IDX_W = $clog2(MAX_LIGHTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W = QPTR_W + 1;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [15:0] INTENSITY_MAX = 16'd62259;
	localparam logic signed [15:0] DEFAULT_XY = 16'sd8151;
	localparam logic signed [15:0] DEFAULT_Z = -16'sd11644;
	localparam logic signed [39:0] FORCED_Z = -40'sd16777;
	localparam logic [16:0] UNIT_ONE = 17'd65536;
	localparam logic [14:0] DIR_ONE = 15'd16384;

	localparam logic [5:0] RATIO_STEPS = 6'd32;
	localparam logic [5:0] UNIT_STEPS = 6'd22;
	localparam logic [5:0] DIR_STEPS = 6'd14;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_ADD,
		OP_QUERY,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [1:0] action;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic [15:0] brightness;
		logic [23:0] radius;
	} req_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [15:0] intensity;
		logic status;
	} rsp_t;

	typedef struct packed {
		op_t op;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic [15:0] strength;
		logic [47:0] reach_sq;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic [47:0] num;
		logic [47:0] den;
		logic [5:0] steps;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic [32:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic start;
		logic [63:0] value;
	} sqrt_req_t;

	typedef struct packed {
		logic busy;
		logic [31:0] root;
	} sqrt_rsp_t;

endpackage

FILE: rtl/point_light_direction_sum_unit.sv
`timescale 1ns / 1ps
// Point light direction sum. Requests arrive on req (valid/ready) and each beat
// gives exactly one beat on rsp (valid/ready), in request order.
// A request clears the light table, adds one light, or queries a point. A query
// returns the normalized summed light direction and its clamped intensity.
// A two-entry queue sits between the request side and the execution engine, so
// up to two requests are taken while the engine works or the response waits.
// Clear, add and unused actions go from idle straight to the response state;
// an add to a full table stores nothing and sets status. A query visits every
// stored light; only lights within reach go through the divider and square-root
// steps. Queries use one shared restoring divider and one shared square-root
// unit, each retiring one bit per cycle.
// Reset empties the light table and the queue and drops any pending response.
// When the receiver holds rsp_ready low, the engine finishes its current item
// and waits; the queue keeps taking requests until it is full.
module point_light_direction_sum_unit import plds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output rsp_t rsp
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	plds_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd)
	);

	plds_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

endmodule

FILE: rtl/plds_front.sv
`timescale 1ns / 1ps
module plds_front import plds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_t req,
	output logic cmd_valid,
	input logic cmd_ready,
	output cmd_t cmd
);

	cmd_t queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QFILL_W-1:0] fill_q;
	cmd_t entry;
	logic push;
	logic pop;

	always_comb begin
		unique case (req.action)
			ACT_CLEAR: entry.op = OP_CLEAR;
			ACT_ADD: entry.op = OP_ADD;
			ACT_QUERY: entry.op = OP_QUERY;
			default: entry.op = OP_NOP;
		endcase
		entry.pos_x = req.pos_x;
		entry.pos_y = req.pos_y;
		entry.pos_z = req.pos_z;
		entry.strength = req.brightness;
		entry.reach_sq = {24'd0, req.radius} * {24'd0, req.radius};
	end

	assign req_ready = (fill_q != QFILL_W'(QUEUE_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd = queue_q[rd_ptr_q];
	assign push = req_valid && req_ready;
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/plds_div.sv
`timescale 1ns / 1ps
module plds_div import plds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);

	logic busy_q;
	logic [5:0] cnt_q;
	logic [47:0] rem_q;
	logic [47:0] den_q;
	logic [32:0] quo_q;
	logic [48:0] rem2;

	assign rem2 = {rem_q, 1'b0};
	assign rsp.busy = busy_q;
	assign rsp.quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && cnt_q == 6'd1) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			cnt_q <= req.steps;
			if (req.num >= req.den) begin
				rem_q <= req.num - req.den;
				quo_q <= 33'd1;
			end else begin
				rem_q <= req.num;
				quo_q <= '0;
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (rem2 >= {1'b0, den_q}) begin
				rem_q <= 48'(rem2 - {1'b0, den_q});
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= rem2[47:0];
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end

endmodule

FILE: rtl/plds_sqrt.sv
`timescale 1ns / 1ps
module plds_sqrt import plds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input sqrt_req_t req,
	output sqrt_rsp_t rsp
);

	localparam logic [63:0] TOP_BIT = 64'h4000_0000_0000_0000;

	logic busy_q;
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = r_q + bit_q;
	assign rsp.busy = busy_q;
	assign rsp.root = r_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q <= req.value;
			r_q <= '0;
			bit_q <= TOP_BIT;
		end else if (busy_q) begin
			bit_q <= bit_q >> 2;
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

endmodule

FILE: rtl/plds_back.sv
`timescale 1ns / 1ps
module plds_back import plds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input cmd_t cmd,
	output logic rsp_valid,
	input logic rsp_ready,
	output rsp_t rsp
);

	typedef enum logic [22:0] {
		S_IDLE = 23'b1 << 0,
		S_READ = 23'b1 << 1,
		S_DIFF = 23'b1 << 2,
		S_SQM = 23'b1 << 3,
		S_SQA = 23'b1 << 4,
		S_CHECK = 23'b1 << 5,
		S_WAIT1 = 23'b1 << 6,
		S_WAIT2 = 23'b1 << 7,
		S_WMUL = 23'b1 << 8,
		S_WGT = 23'b1 << 9,
		S_UDIV = 23'b1 << 10,
		S_UWAIT = 23'b1 << 11,
		S_UMUL = 23'b1 << 12,
		S_UACC = 23'b1 << 13,
		S_NEXT = 23'b1 << 14,
		S_LEN = 23'b1 << 15,
		S_SHIFT = 23'b1 << 16,
		S_LMUL = 23'b1 << 17,
		S_LACC = 23'b1 << 18,
		S_LWAIT = 23'b1 << 19,
		S_DDIV = 23'b1 << 20,
		S_DWAIT = 23'b1 << 21,
		S_OUT = 23'b1 << 22
	} state_t;

	state_t state_q;
	state_t state_d;
	logic [CNT_W-1:0] count_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic signed [23:0] tab_x [MAX_LIGHTS];
	logic signed [23:0] tab_y [MAX_LIGHTS];
	logic signed [23:0] tab_z [MAX_LIGHTS];
	logic [15:0] tab_s [MAX_LIGHTS];
	logic [47:0] tab_r [MAX_LIGHTS];
	logic signed [23:0] rd_x_q;
	logic signed [23:0] rd_y_q;
	logic signed [23:0] rd_z_q;
	logic [15:0] rd_s_q;
	logic [47:0] rd_r_q;
	logic tab_we;

	cmd_t cmd_q;
	rsp_t res_q;
	rsp_t res_init;
	logic [CNT_W-1:0] idx_q;
	logic [1:0] k_q;
	logic pass_q;
	logic [24:0] dmag_q [3];
	logic dneg_q [3];
	logic [49:0] d2_q;
	logic [29:0] dist_q;
	logic [16:0] q_q;
	logic [32:0] w_q;
	logic [16:0] u_q;
	logic signed [39:0] sum_q [3];
	logic [39:0] m_q [3];
	logic [3:0] s_q;
	logic [61:0] ss_q;
	logic [30:0] len_q;
	logic [65:0] p_q;

	logic [32:0] mul_a;
	logic [32:0] mul_b;
	div_req_t div_req;
	div_rsp_t div_rsp;
	sqrt_req_t sqrt_req;
	sqrt_rsp_t sqrt_rsp;

	logic out_free;
	logic in_reach;
	logic last_k;
	logic last_light;
	logic any_big;
	logic [61:0] ss_total;
	logic signed [24:0] diff [3];
	logic signed [39:0] contrib;
	logic [47:0] wide_len;
	logic [39:0] scaled_len;
	logic [14:0] dir_mag;
	logic [16:0] root_q;
	logic [16:0] quo_u;

	plds_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	plds_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.req(sqrt_req),
		.rsp(sqrt_rsp)
	);

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign in_reach = (d2_q != '0) && (d2_q <= {2'b0, rd_r_q});
	assign last_k = (k_q == 2'd2);
	assign last_light = ((idx_q + 1'b1) >= count_q);
	assign any_big = (m_q[0][39:30] != '0) || (m_q[1][39:30] != '0) ||
		(m_q[2][39:30] != '0);
	assign ss_total = ss_q + p_q[61:0];
	assign tab_we = (state_q == S_IDLE) && cmd_valid && (cmd.op == OP_ADD) &&
		(count_q != CNT_W'(MAX_LIGHTS));

	assign diff[0] = 25'(cmd_q.pos_x) - 25'(rd_x_q);
	assign diff[1] = 25'(cmd_q.pos_y) - 25'(rd_y_q);
	assign diff[2] = 25'(cmd_q.pos_z) - 25'(rd_z_q);
	assign contrib = {6'd0, p_q[49:16]};
	assign wide_len = {17'd0, sqrt_rsp.root[30:0]} << s_q;
	assign scaled_len = wide_len[47:8];
	assign dir_mag = (div_rsp.quo > 33'(DIR_ONE)) ? DIR_ONE : div_rsp.quo[14:0];
	assign root_q = (sqrt_rsp.root > 32'(UNIT_ONE)) ? UNIT_ONE : sqrt_rsp.root[16:0];
	assign quo_u = (div_rsp.quo > 33'(UNIT_ONE)) ? UNIT_ONE : div_rsp.quo[16:0];

	always_comb begin
		res_init = '0;
		if (cmd.op == OP_ADD && count_q == CNT_W'(MAX_LIGHTS)) begin
			res_init.status = 1'b1;
		end
		if (cmd.op == OP_QUERY && count_q == '0) begin
			res_init.dir_x = DEFAULT_XY;
			res_init.dir_y = DEFAULT_XY;
			res_init.dir_z = DEFAULT_Z;
			res_init.intensity = INTENSITY_MAX;
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQM: begin
				mul_a = {8'd0, dmag_q[k_q]};
				mul_b = {8'd0, dmag_q[k_q]};
			end
			S_WMUL: begin
				mul_a = {17'd0, rd_s_q};
				mul_b = {16'd0, 17'(UNIT_ONE - q_q)};
			end
			S_UMUL: begin
				mul_a = {16'd0, u_q};
				mul_b = w_q;
			end
			S_LMUL: begin
				mul_a = {3'd0, m_q[k_q][29:0]};
				mul_b = {3'd0, m_q[k_q][29:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_req = '0;
		sqrt_req = '0;
		unique case (state_q)
			S_CHECK: begin
				div_req.start = in_reach;
				div_req.num = d2_q[47:0];
				div_req.den = rd_r_q;
				div_req.steps = RATIO_STEPS;
				sqrt_req.start = in_reach;
				sqrt_req.value = {4'd0, d2_q[47:0], 12'd0};
			end
			S_WAIT1: begin
				sqrt_req.start = !div_rsp.busy && !sqrt_rsp.busy;
				sqrt_req.value = {31'd0, div_rsp.quo};
			end
			S_UDIV: begin
				div_req.start = 1'b1;
				div_req.num = {23'd0, dmag_q[k_q]};
				div_req.den = {18'd0, dist_q};
				div_req.steps = UNIT_STEPS;
			end
			S_LACC: begin
				sqrt_req.start = last_k;
				sqrt_req.value = {2'd0, ss_total};
			end
			S_DDIV: begin
				div_req.start = 1'b1;
				div_req.num = {18'd0, m_q[k_q][29:0]};
				div_req.den = {17'd0, len_q};
				div_req.steps = DIR_STEPS;
			end
			default: begin
				div_req = '0;
				sqrt_req = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = (cmd.op == OP_QUERY && count_q != '0) ? S_READ : S_OUT;
				end
			end
			S_READ: state_d = S_DIFF;
			S_DIFF: state_d = S_SQM;
			S_SQM: state_d = S_SQA;
			S_SQA: state_d = last_k ? S_CHECK : S_SQM;
			S_CHECK: state_d = in_reach ? S_WAIT1 : S_NEXT;
			S_WAIT1: begin
				if (!div_rsp.busy && !sqrt_rsp.busy) begin
					state_d = S_WAIT2;
				end
			end
			S_WAIT2: begin
				if (!sqrt_rsp.busy) begin
					state_d = S_WMUL;
				end
			end
			S_WMUL: state_d = S_WGT;
			S_WGT: state_d = S_UDIV;
			S_UDIV: state_d = S_UWAIT;
			S_UWAIT: begin
				if (!div_rsp.busy) begin
					state_d = S_UMUL;
				end
			end
			S_UMUL: state_d = S_UACC;
			S_UACC: state_d = last_k ? S_NEXT : S_UDIV;
			S_NEXT: state_d = last_light ? S_LEN : S_READ;
			S_LEN: state_d = S_SHIFT;
			S_SHIFT: state_d = any_big ? S_SHIFT : S_LMUL;
			S_LMUL: state_d = S_LACC;
			S_LACC: state_d = last_k ? S_LWAIT : S_LMUL;
			S_LWAIT: begin
				if (!sqrt_rsp.busy) begin
					state_d = pass_q ? S_DDIV : S_LEN;
				end
			end
			S_DDIV: state_d = S_DWAIT;
			S_DWAIT: begin
				if (!div_rsp.busy) begin
					state_d = last_k ? S_OUT : S_DDIV;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && cmd_valid && cmd.op == OP_CLEAR) begin
				count_q <= '0;
			end else if (tab_we) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tab_we) begin
			tab_x[count_q[IDX_W-1:0]] <= cmd.pos_x;
			tab_y[count_q[IDX_W-1:0]] <= cmd.pos_y;
			tab_z[count_q[IDX_W-1:0]] <= cmd.pos_z;
			tab_s[count_q[IDX_W-1:0]] <= cmd.strength;
			tab_r[count_q[IDX_W-1:0]] <= cmd.reach_sq;
		end
		rd_x_q <= tab_x[idx_q[IDX_W-1:0]];
		rd_y_q <= tab_y[idx_q[IDX_W-1:0]];
		rd_z_q <= tab_z[idx_q[IDX_W-1:0]];
		rd_s_q <= tab_s[idx_q[IDX_W-1:0]];
		rd_r_q <= tab_r[idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		if (state_q == S_OUT && out_free) begin
			rsp_q <= res_q;
		end
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
					res_q <= res_init;
					idx_q <= '0;
					pass_q <= 1'b0;
					for (int i = 0; i < 3; i++) begin
						sum_q[i] <= '0;
					end
				end
			end
			S_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					dneg_q[i] <= diff[i][24];
					dmag_q[i] <= diff[i][24] ? 25'(-diff[i]) : 25'(diff[i]);
				end
				k_q <= '0;
				d2_q <= '0;
			end
			S_SQA: begin
				d2_q <= d2_q + p_q[49:0];
				k_q <= k_q + 1'b1;
			end
			S_WAIT1: begin
				dist_q <= sqrt_rsp.root[29:0];
			end
			S_WAIT2: begin
				q_q <= root_q;
			end
			S_WGT: begin
				w_q <= p_q[32:0];
				k_q <= '0;
			end
			S_UWAIT: begin
				u_q <= quo_u;
			end
			S_UACC: begin
				sum_q[k_q] <= dneg_q[k_q] ? sum_q[k_q] - contrib : sum_q[k_q] + contrib;
				k_q <= k_q + 1'b1;
			end
			S_NEXT: begin
				idx_q <= idx_q + 1'b1;
			end
			S_LEN: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i] <= sum_q[i][39] ? 40'(-sum_q[i]) : 40'(sum_q[i]);
				end
				s_q <= '0;
			end
			S_SHIFT: begin
				if (any_big) begin
					for (int i = 0; i < 3; i++) begin
						m_q[i] <= m_q[i] >> 1;
					end
					s_q <= s_q + 1'b1;
				end else begin
					k_q <= '0;
					ss_q <= '0;
				end
			end
			S_LACC: begin
				ss_q <= ss_total;
				k_q <= k_q + 1'b1;
			end
			S_LWAIT: begin
				len_q <= sqrt_rsp.root[30:0];
				k_q <= '0;
				if (!sqrt_rsp.busy && !pass_q) begin
					pass_q <= 1'b1;
					res_q.intensity <= (scaled_len > 40'(INTENSITY_MAX)) ?
						INTENSITY_MAX : scaled_len[15:0];
					if (!sum_q[2][39]) begin
						sum_q[2] <= FORCED_Z;
					end
				end
			end
			S_DWAIT: begin
				if (!div_rsp.busy) begin
					k_q <= k_q + 1'b1;
					case (k_q)
						2'd0: res_q.dir_x <= sum_q[0][39] ? -16'(dir_mag) : 16'(dir_mag);
						2'd1: res_q.dir_y <= sum_q[1][39] ? -16'(dir_mag) : 16'(dir_mag);
						default: res_q.dir_z <= sum_q[2][39] ? -16'(dir_mag) : 16'(dir_mag);
					endcase
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: bench/point_light_direction_sum_unit_tb.sv
`timescale 1ns / 1ps
module point_light_direction_sum_unit_tb;
	import plds_pkg::*;

	localparam longint CYCLE_LIMIT = 6000000;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	point_light_direction_sum_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	int send_idle_pct;
	int recv_idle_pct;
	int mismatches;
	longint cycles;
	rsp_t light_results[$];

	// Private copy of the light table used to predict each beat.
	int table_count;
	logic signed [23:0] table_x[MAX_LIGHTS];
	logic signed [23:0] table_y[MAX_LIGHTS];
	logic signed [23:0] table_z[MAX_LIGHTS];
	logic [15:0] table_strength[MAX_LIGHTS];
	logic [47:0] table_reach_sq[MAX_LIGHTS];

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] magnitude(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [63:0] shifted_length(inout logic [63:0] m[3], output int sh);
		sh = 0;
		while ((m[0] >> sh) >= 64'd1 << 30 || (m[1] >> sh) >= 64'd1 << 30 ||
				(m[2] >> sh) >= 64'd1 << 30)
			sh++;
		for (int k = 0; k < 3; k++)
			m[k] = m[k] >> sh;
		return int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
	endfunction

	function automatic rsp_t predict_light_result(input req_t r);
		rsp_t o;
		logic signed [63:0] acc[3];
		logic signed [63:0] d[3];
		logic [63:0] m[3];
		logic [63:0] d2, r2, q, w, root_dist, u, c, len;
		logic [127:0] ratio;
		int sh;
		o = '0;
		case (r.action)
		ACT_CLEAR: begin
			table_count = 0;
		end
		ACT_ADD: begin
			if (table_count >= MAX_LIGHTS) begin
				o.status = 1'b1;
			end else begin
				table_x[table_count] = r.pos_x;
				table_y[table_count] = r.pos_y;
				table_z[table_count] = r.pos_z;
				table_strength[table_count] = r.brightness;
				table_reach_sq[table_count] = 48'(r.radius) * 48'(r.radius);
				table_count++;
			end
		end
		ACT_QUERY: begin
			if (table_count == 0) begin
				o.dir_x = DEFAULT_XY;
				o.dir_y = DEFAULT_XY;
				o.dir_z = DEFAULT_Z;
				o.intensity = INTENSITY_MAX;
				return o;
			end
			for (int k = 0; k < 3; k++)
				acc[k] = 0;
			for (int i = 0; i < table_count; i++) begin
				d[0] = 64'(r.pos_x) - 64'(table_x[i]);
				d[1] = 64'(r.pos_y) - 64'(table_y[i]);
				d[2] = 64'(r.pos_z) - 64'(table_z[i]);
				d2 = 0;
				for (int k = 0; k < 3; k++)
					d2 += magnitude(d[k]) * magnitude(d[k]);
				r2 = 64'(table_reach_sq[i]);
				if (d2 == 0 || d2 > r2)
					continue;
				if (d2 == r2)
					ratio = 128'd1 << 32;
				else
					ratio = (128'(d2) << 32) / 128'(r2);
				q = int_sqrt(ratio[63:0]);
				if (q > 65536)
					q = 65536;
				w = 64'(table_strength[i]) * (64'd65536 - q);
				root_dist = int_sqrt(d2 << 12);
				if (root_dist == 0)
					continue;
				for (int k = 0; k < 3; k++) begin
					u = (magnitude(d[k]) << 22) / root_dist;
					if (u > 65536)
						u = 65536;
					c = (u * w) >> 16;
					acc[k] = d[k] < 0 ? acc[k] - $signed(c) : acc[k] + $signed(c);
				end
			end
			for (int k = 0; k < 3; k++)
				m[k] = magnitude(acc[k]);
			len = shifted_length(m, sh);
			len = (len << sh) >> 8;
			o.intensity = len > INTENSITY_MAX ? INTENSITY_MAX : len[15:0];
			if (acc[2] >= 0)
				acc[2] = 64'(FORCED_Z);
			for (int k = 0; k < 3; k++)
				m[k] = magnitude(acc[k]);
			len = shifted_length(m, sh);
			for (int k = 0; k < 3; k++) begin
				c = len != 0 ? (m[k] << 14) / len : 0;
				if (c > 16384)
					c = 16384;
				d[k] = acc[k] < 0 ? -$signed(c) : $signed(c);
			end
			o.dir_x = d[0][15:0];
			o.dir_y = d[1][15:0];
			o.dir_z = d[2][15:0];
		end
		default: begin
		end
		endcase
		return o;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
		mismatches++;
	endtask

	task automatic send_beat(input req_t item);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(negedge clk);
		while (!req_ready);
		light_results = {light_results, predict_light_result(item)};
		@(posedge clk);
	endtask

	task automatic wait_for_results();
		while (light_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic req_t make_req(input logic [1:0] act, input int x, input int y,
			input int z, input int br, input int rad);
		req_t r;
		r.action = act;
		r.pos_x = x[23:0];
		r.pos_y = y[23:0];
		r.pos_z = z[23:0];
		r.brightness = br[15:0];
		r.radius = rad[23:0];
		return r;
	endfunction

	function automatic req_t random_req();
		return make_req(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
			$urandom);
	endfunction

	function automatic int spread_offset(input int spread);
		return $urandom_range(0, 2 * spread) - spread;
	endfunction

	always @(posedge clk)
		rsp_ready <= $urandom_range(0, 99) >= recv_idle_pct;

	always @(negedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (light_results.size() == 0) begin
				report_mismatch("unexpected beat", rsp.intensity, 0);
			end else begin
				want = light_results.pop_front();
				if (rsp.dir_x !== want.dir_x)
					report_mismatch("dir_x", rsp.dir_x, want.dir_x);
				if (rsp.dir_y !== want.dir_y)
					report_mismatch("dir_y", rsp.dir_y, want.dir_y);
				if (rsp.dir_z !== want.dir_z)
					report_mismatch("dir_z", rsp.dir_z, want.dir_z);
				if (rsp.intensity !== want.intensity)
					report_mismatch("intensity", rsp.intensity, want.intensity);
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic test_directed_cases();
		send_beat(make_req(ACT_QUERY, 0, 0, 0, 0, 0));
		send_beat(make_req(OP_NOP, -1, -1, -1, 65535, 16777215));
		send_beat(make_req(ACT_ADD, 8388607, 8388607, 8388607, 65535, 16777215));
		send_beat(make_req(ACT_QUERY, -8388608, -8388608, -8388608, 0, 0));
		send_beat(make_req(ACT_QUERY, 8388607, 8388607, 8388607, 0, 0));
		send_beat(make_req(ACT_QUERY, 8388607, 8388607, 8388000, 0, 0));
		send_beat(make_req(ACT_ADD, 0, 0, 0, 256, 0));
		send_beat(make_req(ACT_QUERY, 0, 0, 0, 0, 0));
		send_beat(make_req(ACT_ADD, 1000, -2000, 500, 0, 4096));
		send_beat(make_req(ACT_ADD, 100, 100, 100, 65535, 1024));
		send_beat(make_req(ACT_QUERY, 300, 200, -100, 0, 0));
		send_beat(make_req(ACT_QUERY, 100, 100, 1124, 0, 0));
		send_beat(make_req(ACT_QUERY, -8388608, 0, 0, 0, 0));
		send_beat(make_req(ACT_CLEAR, -8388608, -8388608, -8388608, 65535, 16777215));
		send_beat(make_req(ACT_QUERY, 5, 5, 5, 0, 0));
		send_beat(make_req(ACT_ADD, -8388608, -8388608, -8388608, 0, 0));
		send_beat(make_req(ACT_QUERY, -8388608, -8388608, -8388608, 0, 0));
	endtask

	task automatic test_table_overflow();
		send_beat(make_req(ACT_CLEAR, 0, 0, 0, 0, 0));
		for (int i = 0; i < MAX_LIGHTS + 2; i++)
			send_beat(make_req(ACT_ADD, spread_offset(4096), spread_offset(4096),
				spread_offset(4096), $urandom, $urandom_range(1024, 16384)));
		send_beat(make_req(ACT_QUERY, 0, 0, -256, 0, 0));
		send_beat(make_req(ACT_CLEAR, 0, 0, 0, 0, 0));
	endtask

	task automatic test_light_scenes(input int n);
		int sent;
		int nl;
		int cx, cy, cz, spread;
		int ox, oy, oz;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) == 0) begin
				send_beat(random_req());
				sent++;
				continue;
			end
			if ($urandom_range(0, 2) != 0) begin
				send_beat(make_req(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom,
					$urandom));
				sent++;
			end
			nl = $urandom_range(0, 9) == 0 ? $urandom_range(10, 18) : $urandom_range(1, 4);
			cx = $urandom;
			cy = $urandom;
			cz = $urandom;
			spread = 1 << $urandom_range(2, 20);
			for (int i = 0; i < nl; i++) begin
				ox = cx + spread_offset(spread);
				oy = cy + spread_offset(spread);
				oz = cz + spread_offset(spread);
				send_beat(make_req(ACT_ADD, ox, oy, oz, $urandom,
					$urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 3 * spread)));
				sent++;
			end
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 5) == 0)
					send_beat(make_req(ACT_QUERY, ox, oy, oz, $urandom, $urandom));
				else
					send_beat(make_req(ACT_QUERY, cx + spread_offset(spread),
						cy + spread_offset(spread), cz + spread_offset(spread),
						$urandom, $urandom));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		rsp_ready <= 1'b0;
		send_idle_pct = 22;
		recv_idle_pct = 57;
		table_count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_table_overflow();
		test_light_scenes(140);
		req_valid <= 1'b0;
		wait_for_results();
		@(posedge clk);
		send_idle_pct = 57;
		recv_idle_pct = 22;
		test_light_scenes(140);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_light_scenes(150);
		req_valid <= 1'b0;
		wait_for_results();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
